>>> design/mwsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer package
// Shared constants, fixed-point widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mwsm_pkg;

  // Default sample width of the command and wheel ports.
  localparam int SampleWidthDef = 16;

  // Internal fixed point: one is 2^30. Values are held in 36-bit signed words.
  localparam int QW = 36;
  localparam logic signed [QW-1:0] QOne = 36'sd1073741824;

  localparam int CordicSteps = 28;

  // Gain compensation, 1/sqrt(2), and the pivot vector scales in Q.30.
  localparam logic signed [QW-1:0] CordicGain = 36'sd652032874;
  localparam logic signed [QW-1:0] InvSqrt2   = 36'sd759250125;
  localparam logic signed [QW-1:0] PivA =
    QW'((64'sd19000 * 64'sd1518500250 + 64'sd33425) / 64'sd66850);
  localparam logic signed [QW-1:0] PivB =
    QW'((64'sd27500 * 64'sd1518500250 + 64'sd33425) / 64'sd66850);

  // Register indexes of the configuration port.
  localparam logic [2:0] RegSquared  = 3'd0;
  localparam logic [2:0] RegDeadband = 3'd1;
  localparam logic [2:0] RegMode     = 3'd2;
  localparam logic [2:0] RegMaxOut   = 3'd3;
  localparam logic [2:0] RegInvert   = 3'd4;

  // Drive modes.
  typedef enum logic [2:0] {
    ModeOmni   = 3'd0,
    ModeStrafe = 3'd1,
    ModeArcade = 3'd2,
    ModePivFl  = 3'd3,
    ModePivFr  = 3'd4,
    ModePivRl  = 3'd5,
    ModePivRr  = 3'd6,
    ModeNone   = 3'd7
  } mode_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Arithmetic shift right, which is a floor division by 2^n.
  function automatic logic signed [QW-1:0] asr_fl(input logic signed [QW-1:0] v,
                                                  input logic [4:0] n);
    return v >>> n;
  endfunction

  // Q.30 product rounded half up: floor((a*b + 1/2) / one).
  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = (2*QW)'(a) * (2*QW)'(b) + (2*QW)'(64'sd536870912);
    return QW'(p >>> 30);
  endfunction

endpackage : mwsm_pkg
`default_nettype wire

>>> design/mecanum_wheel_speed_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer
// Field-oriented mecanum inverse kinematics: one drive command in, four
// wheel speeds out.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries one command beat: x_speed,
//   y_speed, turn_rate and heading. The output channel (out_valid/out_stall)
//   carries one beat of four wheel speeds per command, in order.
//   Configuration is written through cfg_we/cfg_index/cfg_data while the
//   block is idle.
//   Throughput is one beat per cycle while the output is not stalled. The
//   register stages are: shaping (3), quadrant fold, 28 CORDIC rotation
//   stages, gain, radicand, square root (32 stages, one result bit each),
//   mixing (2), peak search, divisor setup, normalizing divide (one
//   quotient bit per stage), inversion and output scaling.
//   A stall on the output freezes the whole pipeline; in_stall follows it,
//   so no beat is lost or repeated. Reset empties the pipeline and loads the
//   register defaults (max_output full scale, everything else zero).
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer
  import mwsm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SampleWidthDef
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [14:0]                    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_speed,
  input  wire logic signed [SAMPLE_WIDTH-1:0] y_speed,
  input  wire logic signed [SAMPLE_WIDTH-1:0] turn_rate,
  input  wire logic signed [SAMPLE_WIDTH-1:0] heading,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      front_left,
  output logic signed [SAMPLE_WIDTH-1:0]      front_right,
  output logic signed [SAMPLE_WIDTH-1:0]      rear_left,
  output logic signed [SAMPLE_WIDTH-1:0]      rear_right
);

  localparam int Frac = SAMPLE_WIDTH - 1;
  localparam int RtW  = 32;              // root width (hypotenuse < 2^31)
  localparam int SqW  = 2 * RtW;         // radicand width
  localparam int DivSteps = 32;          // quotient bits (quotient <= 2^30)
  localparam int OutSh = 15 + 30 - Frac;

  // --------------------------------------------------------------------------
  // Configuration registers.
  logic        squared_inputs;
  logic [14:0] deadband;
  logic [2:0]  drive_mode;
  logic [14:0] max_output;
  logic [3:0]  invert_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      squared_inputs <= 1'b0;
      deadband       <= '0;
      drive_mode     <= '0;
      max_output     <= 15'h7FFF;
      invert_mask    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSquared:  squared_inputs <= cfg_data[0];
        RegDeadband: deadband       <= cfg_data;
        RegMode:     drive_mode     <= cfg_data[2:0];
        RegMaxOut:   max_output     <= cfg_data;
        RegInvert:   invert_mask    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the output beat is held.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // Stage A: widen to Q.30 (inputs are already within +-1).
  function automatic logic signed [QW-1:0] to_q(input logic signed [SAMPLE_WIDTH-1:0] v);
    return QW'(v) <<< (30 - Frac);
  endfunction

  logic                 a_vld;
  logic signed [QW-1:0] a_x, a_y, a_r;
  logic [31:0]          a_ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
    if (adv) begin
      a_x   <= to_q(x_speed);
      a_y   <= to_q(y_speed);
      a_r   <= to_q(turn_rate);
      a_ang <= {heading, {(32-SAMPLE_WIDTH){1'b0}}};
    end
  end

  // Stage B: optional signed square, rounded half up on the magnitude.
  function automatic logic signed [QW-1:0] sq_sgn(input logic signed [QW-1:0] v);
    logic [QW-1:0]   m;
    logic [2*QW-1:0] p;
    m = v[QW-1] ? QW'(-v) : QW'(v);
    p = (2*QW)'(m) * (2*QW)'(m) + (2*QW)'(64'd536870912);
    p = p >> 30;
    return v[QW-1] ? -$signed(QW'(p)) : $signed(QW'(p));
  endfunction

  logic                 b_vld;
  logic signed [QW-1:0] b_x, b_y, b_r;
  logic [31:0]          b_ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
    if (adv) begin
      b_x   <= squared_inputs ? sq_sgn(a_x) : a_x;
      b_y   <= squared_inputs ? sq_sgn(a_y) : a_y;
      b_r   <= squared_inputs ? sq_sgn(a_r) : a_r;
      b_ang <= a_ang;
    end
  end

  // Stage C: deadband, strictly below the threshold goes to zero.
  function automatic logic signed [QW-1:0] dband(input logic signed [QW-1:0] v,
                                                 input logic [14:0] db);
    logic [QW-1:0] m;
    m = v[QW-1] ? QW'(-v) : QW'(v);
    return (m < (QW'(db) << 15)) ? '0 : v;
  endfunction

  logic                 c_vld;
  logic signed [QW-1:0] c_x, c_y, c_r;
  logic [31:0]          c_ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= b_vld;
    end
    if (adv) begin
      c_x   <= dband(b_x, deadband);
      c_y   <= dband(b_y, deadband);
      c_r   <= dband(b_r, deadband);
      c_ang <= b_ang;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC rotation, rotation command rides along.
  logic                 k_vld;
  logic signed [QW-1:0] k_x, k_y, k_r;

  mwsm_cordic #(.SideW(QW)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (c_vld),
    .in_x     (c_x),
    .in_y     (c_y),
    .in_ang   (c_ang),
    .in_side  (c_r),
    .out_vld  (k_vld),
    .out_x    (k_x),
    .out_y    (k_y),
    .out_side (k_r)
  );

  // Stage G: CORDIC gain compensation.
  logic                 g_vld;
  logic signed [QW-1:0] g_x, g_y, g_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (adv) begin
      g_vld <= k_vld;
    end
    if (adv) begin
      g_x <= mulq(k_x, CordicGain);
      g_y <= mulq(k_y, CordicGain);
      g_r <= k_r;
    end
  end

  // Stage H: squared magnitudes summed as the square-root radicand.
  // Both magnitudes stay below 2^31, so 32-bit magnitudes and 64-bit squares are enough.
  logic                 h_vld;
  logic signed [QW-1:0] h_x, h_y, h_r;
  logic [SqW-1:0]       h_rad;
  logic [RtW-1:0]       gmx, gmy;

  assign gmx = g_x[QW-1] ? RtW'(-g_x) : RtW'(g_x);
  assign gmy = g_y[QW-1] ? RtW'(-g_y) : RtW'(g_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (adv) begin
      h_vld <= g_vld;
    end
    if (adv) begin
      h_x   <= g_x;
      h_y   <= g_y;
      h_r   <= g_r;
      h_rad <= SqW'(gmx) * SqW'(gmx) + SqW'(gmy) * SqW'(gmy);
    end
  end

  // Square root, digit by digit: each stage brings down two radicand bits,
  // tries 4*root+1 against the partial remainder and yields one root bit.
  logic                 s_vld [RtW+1];
  logic signed [QW-1:0] s_x   [RtW+1];
  logic signed [QW-1:0] s_y   [RtW+1];
  logic signed [QW-1:0] s_r   [RtW+1];
  logic [SqW-1:0]       s_rad [RtW+1];
  logic [RtW+1:0]       s_rem [RtW+1];
  logic [RtW-1:0]       s_rt  [RtW+1];

  always_comb begin
    s_vld[0] = h_vld;
    s_x[0]   = h_x;
    s_y[0]   = h_y;
    s_r[0]   = h_r;
    s_rad[0] = h_rad;
    s_rem[0] = '0;
    s_rt[0]  = '0;
  end

  for (genvar i = 0; i < RtW; i++) begin : g_sqrt
    localparam int B = RtW - 1 - i;
    logic [RtW+1:0] shl;
    logic [RtW+1:0] trial;
    assign shl   = {s_rem[i][RtW-1:0], s_rad[i][2*B+1 -: 2]};
    assign trial = {s_rt[i], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        s_vld[i+1] <= 1'b0;
      end else if (adv) begin
        s_vld[i+1] <= s_vld[i];
      end
      if (adv) begin
        s_x[i+1]   <= s_x[i];
        s_y[i+1]   <= s_y[i];
        s_r[i+1]   <= s_r[i];
        s_rad[i+1] <= s_rad[i];
        if (shl >= trial) begin
          s_rem[i+1] <= shl - trial;
          s_rt[i+1]  <= {s_rt[i][RtW-2:0], 1'b1};
        end else begin
          s_rem[i+1] <= shl;
          s_rt[i+1]  <= {s_rt[i][RtW-2:0], 1'b0};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage M1: first-level products of the modes.
  logic                 m_vld;
  logic signed [QW-1:0] m_d, m_s, m_xs, m_h, m_hs, m_x, m_y, m_r;
  logic signed [QW-1:0] sq_h;

  assign sq_h = $signed(QW'(s_rt[RtW]));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= s_vld[RtW];
    end
    if (adv) begin
      m_d  <= mulq(s_x[RtW] - s_y[RtW], InvSqrt2);
      m_s  <= mulq(s_x[RtW] + s_y[RtW], InvSqrt2);
      m_xs <= mulq(s_x[RtW], InvSqrt2);
      m_hs <= mulq(sq_h, InvSqrt2);
      m_h  <= sq_h;
      m_x  <= s_x[RtW];
      m_y  <= s_y[RtW];
      m_r  <= s_r[RtW];
    end
  end

  // Stage M2: wheel mix by mode.
  function automatic logic signed [QW-1:0] smax(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic signed [QW-1:0] mix [4];
  logic signed [QW-1:0] lft, rgt;
  logic signed [QW-1:0] base;

  always_comb begin
    if (m_y > 0) begin
      if (m_x > 0) begin lft = m_y - m_x; rgt = smax(m_y, m_x); end
      else begin lft = smax(m_y, -m_x); rgt = m_y + m_x; end
    end else begin
      if (m_x > 0) begin lft = -smax(-m_y, m_x); rgt = m_y + m_x; end
      else begin lft = m_y - m_x; rgt = -smax(-m_y, -m_x); end
    end
    base = (drive_mode == ModePivRr) ? m_hs : m_h;
    for (int k = 0; k < 4; k++) mix[k] = '0;
    unique case (mode_t'(drive_mode))
      ModeOmni: begin
        mix[0] = m_d + m_r;  mix[1] = m_s + m_r;
        mix[2] = -m_s + m_r; mix[3] = -m_d + m_r;
      end
      ModeStrafe: begin
        mix[0] = m_xs + m_r;  mix[1] = m_xs + m_r;
        mix[2] = -m_xs + m_r; mix[3] = -m_xs + m_r;
      end
      ModeArcade: begin
        mix[0] = lft; mix[1] = rgt; mix[2] = lft; mix[3] = rgt;
      end
      ModePivFl: begin
        mix[0] = '0; mix[1] = mulq(-PivA, base); mix[2] = mulq(-PivB, base);
        mix[3] = -base;
      end
      ModePivFr: begin
        mix[0] = mulq(PivA, base); mix[1] = '0; mix[2] = base;
        mix[3] = mulq(PivB, base);
      end
      ModePivRl: begin
        mix[0] = mulq(-PivB, base); mix[1] = -base; mix[2] = '0;
        mix[3] = mulq(-PivA, base);
      end
      ModePivRr: begin
        mix[0] = base; mix[1] = mulq(PivB, base); mix[2] = mulq(PivA, base);
        mix[3] = '0;
      end
      default: ;
    endcase
  end

  logic                 w_vld;
  logic signed [QW-1:0] w_v [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      w_vld <= 1'b0;
    end else if (adv) begin
      w_vld <= m_vld;
    end
    if (adv) begin
      for (int k = 0; k < 4; k++) w_v[k] <= mix[k];
    end
  end

  // Stage N0: pairwise largest magnitudes, via a registered compare.
  logic [QW-1:0] wm [4];
  always_comb begin
    for (int k = 0; k < 4; k++) wm[k] = w_v[k][QW-1] ? QW'(-w_v[k]) : QW'(w_v[k]);
  end

  logic                 n_vld;
  logic signed [QW-1:0] n_v [4];
  logic [QW-1:0]        n_m01, n_m23;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (adv) begin
      n_vld <= w_vld;
    end
    if (adv) begin
      for (int k = 0; k < 4; k++) n_v[k] <= w_v[k];
      n_m01 <= (wm[0] > wm[1]) ? wm[0] : wm[1];
      n_m23 <= (wm[2] > wm[3]) ? wm[2] : wm[3];
    end
  end

  // Stage N1: divisor and numerators (|w| * one + m/2).
  localparam int NW = QW + 31;
  logic [QW-1:0] nmax;
  assign nmax = (n_m01 > n_m23) ? n_m01 : n_m23;

  logic                 dv_vld [DivSteps+1];
  logic                 dv_on  [DivSteps+1];
  logic [3:0]           dv_neg [DivSteps+1];
  logic signed [QW-1:0] dv_w   [DivSteps+1][4];
  logic [QW-1:0]        dv_den [DivSteps+1];
  logic [NW-1:0]        dv_rem [DivSteps+1][4];
  logic [DivSteps-1:0]  dv_q   [DivSteps+1][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= n_vld;
    end
    if (adv) begin
      dv_on[0]  <= nmax > QOne;
      dv_den[0] <= nmax;
      for (int k = 0; k < 4; k++) begin
        dv_w[0][k]   <= n_v[k];
        dv_neg[0][k] <= n_v[k][QW-1];
        dv_rem[0][k] <= (NW'(n_v[k][QW-1] ? QW'(-n_v[k]) : QW'(n_v[k])) << 30)
                        + NW'(nmax >> 1);
        dv_q[0][k]   <= '0;
      end
    end
  end

  // Restoring divide, one quotient bit per stage for all four wheels.
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    localparam int B = DivSteps - 1 - i;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[i+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[i+1] <= dv_vld[i];
      end
      if (adv) begin
        dv_on[i+1]  <= dv_on[i];
        dv_den[i+1] <= dv_den[i];
        dv_neg[i+1] <= dv_neg[i];
        for (int k = 0; k < 4; k++) begin
          dv_w[i+1][k] <= dv_w[i][k];
          if (dv_rem[i][k] >= (NW'(dv_den[i]) << B)) begin
            dv_rem[i+1][k] <= dv_rem[i][k] - (NW'(dv_den[i]) << B);
            dv_q[i+1][k]   <= dv_q[i][k] | (DivSteps'(1) << B);
          end else begin
            dv_rem[i+1][k] <= dv_rem[i][k];
            dv_q[i+1][k]   <= dv_q[i][k];
          end
        end
      end
    end
  end

  // Stage P: pick normalized value and apply inversion.
  localparam logic [1:0] InvBit [4] = '{2'd0, 2'd2, 2'd1, 2'd3};

  logic                 p_vld;
  logic signed [QW-1:0] p_v [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= dv_vld[DivSteps];
    end
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        logic signed [QW-1:0] nv;
        logic signed [QW-1:0] qv;
        qv = $signed(QW'(dv_q[DivSteps][k]));
        nv = dv_on[DivSteps] ? (dv_neg[DivSteps][k] ? -qv : qv) : dv_w[DivSteps][k];
        p_v[k] <= invert_mask[InvBit[k]] ? -nv : nv;
      end
    end
  end

  // Stage O: output scale, rounding half up and saturation.
  function automatic logic signed [SAMPLE_WIDTH-1:0] scale_out(
      input logic signed [QW-1:0] v, input logic [14:0] mo);
    logic signed [QW+16:0] p;
    logic signed [QW+16:0] s;
    logic signed [QW+16:0] lim;
    p   = (QW+17)'(v) * $signed({1'b0, mo}) + ((QW+17)'(1) <<< (OutSh - 1));
    s   = p >>> OutSh;
    lim = (QW+17)'(1) <<< Frac;
    if (s > lim - 1) s = lim - 1;
    if (s < -lim) s = -lim;
    return s[SAMPLE_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_vld;
    end
    if (adv) begin
      front_left  <= scale_out(p_v[0], max_output);
      front_right <= scale_out(p_v[1], max_output);
      rear_left   <= scale_out(p_v[2], max_output);
      rear_right  <= scale_out(p_v[3], max_output);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  a_stall_follows: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow held output");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(front_left) && $stable(rear_right))
    else $error("held output beat changed");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    s_vld[RtW] |-> (s_rt[RtW] <= RtW'(64'd1518600000)))
    else $error("hypotenuse out of range");

endmodule : mecanum_wheel_speed_mixer
`default_nettype wire

>>> design/mwsm_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mecanum mixer CORDIC rotator
// Pipelined rotation of the x,y vector by a binary angle, one step a stage.
// Carries a side band of other per-beat data along with it.
// ----------------------------------------------------------------------------
module mwsm_cordic
  import mwsm_pkg::*;
#(
  parameter int SideW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire logic                 in_vld,
  input  wire logic signed [QW-1:0] in_x,
  input  wire logic signed [QW-1:0] in_y,
  input  wire logic [31:0]          in_ang,
  input  wire logic [SideW-1:0]     in_side,
  output logic                      out_vld,
  output logic signed [QW-1:0]      out_x,
  output logic signed [QW-1:0]      out_y,
  output logic [SideW-1:0]          out_side
);

  localparam int N = CordicSteps;

  logic                 vld  [N+1];
  logic signed [QW-1:0] xs   [N+1];
  logic signed [QW-1:0] ys   [N+1];
  logic signed [33:0]   zs   [N+1];
  logic [SideW-1:0]     sd   [N+1];

  // Quadrant fold on entry: angles in the back half flip the vector.
  logic [1:0]  quad;
  logic [31:0] zf;
  always_comb begin
    quad = in_ang[31:30];
    zf   = in_ang;
    if (quad == 2'd1 || quad == 2'd2) begin
      zf = in_ang + 32'h80000000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
    end
    if (adv) begin
      xs[0] <= (quad == 2'd1 || quad == 2'd2) ? -in_x : in_x;
      ys[0] <= (quad == 2'd1 || quad == 2'd2) ? -in_y : in_y;
      zs[0] <= 34'($signed(zf));
      sd[0] <= in_side;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [QW-1:0] dx, dy;
    logic signed [33:0]   at;
    assign dx = asr_fl(ys[i], 5'(i));
    assign dy = asr_fl(xs[i], 5'(i));
    assign at = 34'($signed({2'b00, atan_lut(5'(i))}));
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
      if (adv) begin
        sd[i+1] <= sd[i];
        if (!zs[i][33]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - at;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + at;
        end
      end
    end
  end

  assign out_vld  = vld[N];
  assign out_x    = xs[N];
  assign out_y    = ys[N];
  assign out_side = sd[N];

endmodule : mwsm_cordic
`default_nettype wire
